// ----- hw/rtl/ssmf_pkg.sv -----
// ----------------------------------------------------------------------------
// Segmented sieve Mersenne finder package
// Shared widths, constants, the remainder unit interface and the Mersenne test.
// ----------------------------------------------------------------------------
package ssmf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned EXP_W     = 5;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_FINDS = 8;
  localparam logic [DIV_W-1:0] ROOT_RESET = 16'd46340;

  // Request to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } rem_req_t;

  // Answer of the remainder unit; rem holds while done is high.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } rem_rsp_t;

  // Outcome of the Mersenne test on one number.
  typedef struct packed {
    logic             hit;
    logic [EXP_W-1:0] exp;
  } merz_t;

  // A number p is reported when p+1 is 2^k with k in 0..31, except p = 1.
  function automatic merz_t merz_check(input logic [DATA_W-1:0] p);
    logic [DATA_W:0] pp1;
    merz_t           res;
    pp1     = {1'b0, p} + 33'd1;
    res.hit = 1'b0;
    res.exp = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (pp1 == (33'd1 << b) && b != 1) begin
        res.hit = 1'b1;
        res.exp = EXP_W'(b);
      end
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/ssmf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssmf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ssmf_rem.sv -----
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssmf_rem import ssmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic                      busy_q;
  logic                      done_q;
  logic [$clog2(DATA_W)-1:0] cnt_q;
  logic [DATA_W-1:0]         num_q;
  logic [DIV_W-1:0]          div_q;
  logic [DIV_W-1:0]          rem_q;
  logic [DIV_W:0]            shifted;
  logic [DIV_W:0]            rem_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem_q, num_q[DATA_W-1]};
    if (shifted >= {1'b0, div_q}) begin
      rem_d = shifted - {1'b0, div_q};
    end else begin
      rem_d = shifted;
    end
  end

  // Control and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.dividend;
        div_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d[DIV_W-1:0];
        num_q <= {num_q[DATA_W-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == $clog2(DATA_W)'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- hw/rtl/segmented_sieve_mersenne_finder_top.sv -----
// ----------------------------------------------------------------------------
// Segmented sieve Mersenne finder, top level
// Sieves one window of numbers per item and reports Mersenne primes in it.
// ----------------------------------------------------------------------------
// Per item: clear the bitmaps; check each base candidate; for each base prime,
// mark its multiples in the base bitmap, reduce the window start modulo it and
// mark its multiples in the window bitmap; then check each scanned number and
// emit each result. The bitmap memories' single write ports pace these steps.
// One item at a time; the next is taken after its last result is delivered.
// Reset: base_root returns to 46340; bitmaps are cleared at each item unless its window end lies below its start.
module segmented_sieve_mersenne_finder_top import ssmf_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 65536,
  parameter int unsigned BASE_SIZE   = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DIV_W-1:0]  cfg_base_root_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] window_start_i,
  input  logic [DATA_W-1:0] window_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EXP_W-1:0]  exponent_o,
  output logic              found_o,
  output logic              last_o
);

  localparam int unsigned WA = $clog2(WINDOW_SIZE);
  localparam int unsigned BA = $clog2(BASE_SIZE);
  localparam int unsigned CW = ((WA > DIV_W) ? WA : DIV_W) + 1;
  localparam int unsigned OW = ((WA > DIV_W + 1) ? WA : DIV_W + 1) + 1;
  localparam logic [DIV_W-1:0]  ROOT_MAX = DIV_W'(BASE_SIZE - 1);
  localparam logic [DATA_W-1:0] SPAN_MAX = DATA_W'(WINDOW_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_B_RD, ST_B_CHK, ST_B_MARK, ST_DIV,
    ST_W_INIT, ST_W_MARK, ST_S_RD, ST_S_CHK, ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [DIV_W-1:0]         base_root_q;
  logic [DATA_W-1:0]        s_q;
  logic [WA-1:0]            span_q;
  logic [DIV_W-1:0]         root_q;
  logic [CW-1:0]            clr_q;
  logic [DIV_W:0]           i_q;
  logic [DIV_W:0]           j_q;
  logic [OW-1:0]            off_q;
  logic [WA-1:0]            q_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [$clog2(MAX_FINDS)-1:0] idx_q;
  logic [EXP_W-1:0]         exp_q [MAX_FINDS];
  logic                     div_start_q;

  rem_req_t                 rem_req;
  rem_rsp_t                 rem_rsp;

  logic                     base_we, win_we, base_wdata, win_wdata;
  logic [BA-1:0]            base_waddr, base_raddr;
  logic [WA-1:0]            win_waddr, win_raddr;
  logic                     base_rdata, win_rdata;

  logic [DATA_W-1:0]        diff;
  logic [DIV_W:0]           i_next;
  logic [OW-1:0]            off0;
  logic [DATA_W:0]          first_sum;
  logic [OW-1:0]            off_init;
  logic [DATA_W-1:0]        p_cur;
  merz_t                    merz;
  logic                     hit_now;
  logic [CNT_W-1:0]         cnt_next;

  // Configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  // Handshake and result fields.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign found_o     = (cnt_q != '0);
  assign exponent_o  = (cnt_q != '0) ? exp_q[idx_q] : '0;
  assign last_o      = (cnt_q == '0) || ({1'b0, idx_q} == cnt_q - 1'b1);

  // Helper values for the sieve steps.
  always_comb begin
    diff      = window_end_i - window_start_i;
    i_next    = i_q + 1'b1;
    off0      = (rem_rsp.rem != '0) ? OW'(i_q - {1'b0, rem_rsp.rem}) : '0;
    first_sum = {1'b0, s_q} + (DATA_W + 1)'(off0);
    off_init  = (first_sum == (DATA_W + 1)'(i_q)) ? off0 + OW'(i_q) : off0;
    p_cur     = s_q + DATA_W'(q_q);
    merz      = merz_check(p_cur);
    hit_now   = !win_rdata && merz.hit;
    cnt_next  = cnt_q + CNT_W'(hit_now);
  end

  // Memory port selection per state.
  always_comb begin
    base_we    = 1'b0;
    base_wdata = 1'b0;
    base_waddr = j_q[BA-1:0];
    base_raddr = i_q[BA-1:0];
    win_we     = 1'b0;
    win_wdata  = 1'b0;
    win_waddr  = off_q[WA-1:0];
    win_raddr  = q_q;
    unique case (state_q)
      ST_CLEAR: begin
        base_waddr = clr_q[BA-1:0];
        win_waddr  = clr_q[WA-1:0];
        base_we    = (clr_q <= CW'(root_q));
        win_we     = (clr_q <= CW'(span_q));
      end
      ST_B_MARK: begin
        base_we    = (j_q <= (DIV_W + 1)'(root_q));
        base_wdata = 1'b1;
      end
      ST_W_MARK: begin
        win_we    = (off_q <= OW'(span_q));
        win_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rem_req.start    = div_start_q;
  assign rem_req.dividend = s_q;
  assign rem_req.divisor  = i_q[DIV_W-1:0];

  // Sequencer for clear, base sieve, window marking, scan and emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_root_q <= ROOT_RESET;
      cnt_q       <= '0;
      idx_q       <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        base_root_q <= cfg_base_root_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            s_q    <= window_start_i;
            cnt_q  <= '0;
            idx_q  <= '0;
            clr_q  <= '0;
            span_q <= (diff > SPAN_MAX) ? SPAN_MAX[WA-1:0] : diff[WA-1:0];
            root_q <= (base_root_q > ROOT_MAX) ? ROOT_MAX : base_root_q;
            state_q <= (window_end_i < window_start_i) ? ST_EMIT : ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q >= CW'(span_q) && clr_q >= CW'(root_q)) begin
            i_q <= (DIV_W + 1)'(2);
            q_q <= '0;
            state_q <= (root_q < DIV_W'(2)) ? ST_S_RD : ST_B_RD;
          end
        end
        ST_B_RD: begin
          state_q <= ST_B_CHK;
        end
        ST_B_CHK: begin
          if (base_rdata) begin
            i_q <= i_next;
            state_q <= (i_next > (DIV_W + 1)'(root_q)) ? ST_S_RD : ST_B_RD;
          end else begin
            j_q <= i_q + i_q;
            state_q <= ST_B_MARK;
          end
        end
        ST_B_MARK: begin
          if (j_q <= (DIV_W + 1)'(root_q)) begin
            j_q <= j_q + i_q;
          end else begin
            div_start_q <= 1'b1;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_rsp.done) begin
            state_q <= ST_W_INIT;
          end
        end
        ST_W_INIT: begin
          off_q <= off_init;
          state_q <= ST_W_MARK;
        end
        ST_W_MARK: begin
          if (off_q <= OW'(span_q)) begin
            off_q <= off_q + OW'(i_q);
          end else begin
            i_q <= i_next;
            state_q <= (i_next > (DIV_W + 1)'(root_q)) ? ST_S_RD : ST_B_RD;
          end
        end
        ST_S_RD: begin
          state_q <= ST_S_CHK;
        end
        ST_S_CHK: begin
          if (hit_now) begin
            exp_q[cnt_q[$clog2(MAX_FINDS)-1:0]] <= merz.exp;
          end
          cnt_q <= cnt_next;
          if (cnt_next == CNT_W'(MAX_FINDS) || q_q == span_q) begin
            state_q <= ST_EMIT;
          end else begin
            q_q <= q_q + 1'b1;
            state_q <= ST_S_RD;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 1'b1;
            if (last_o) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Base bitmap.
  ssmf_ram #(.WIDTH(1), .DEPTH(BASE_SIZE)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (base_wdata),
    .raddr_i (base_raddr),
    .rdata_o (base_rdata)
  );

  // Window bitmap.
  ssmf_ram #(.WIDTH(1), .DEPTH(WINDOW_SIZE)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  // Window start modulo base prime.
  ssmf_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

endmodule
